>>> src/timer_count_prescale_select_macros.svh
// ----------------------------------------------------------------------------
// timer_count_prescale_select assertion macros
// Clocked assertion wrappers for the timer programming block.
// ----------------------------------------------------------------------------
`ifndef TIMER_COUNT_PRESCALE_SELECT_MACROS_SVH
`define TIMER_COUNT_PRESCALE_SELECT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TCPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared widths, codes, state types and unit interface structs.
// ----------------------------------------------------------------------------
package tcps_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int INTERVAL_W = 44;
    localparam int TIME_W     = 64;
    localparam int CNT_IN_W   = 32;
    localparam int LOG2_W     = 3;
    localparam int LOAD_W     = 32;
    localparam int TICK_W     = 32;

    // stream packing
    localparam int S_TDATA_W      = 144;
    localparam int S_TUSER_W      = REQ_W;
    localparam int IN_INTERVAL_LSB = 0;
    localparam int IN_DEADLINE_LSB = IN_INTERVAL_LSB + INTERVAL_W;
    localparam int IN_NONEMPTY_BIT = IN_DEADLINE_LSB + TIME_W;
    localparam int IN_COUNTER_LSB  = IN_NONEMPTY_BIT + 1;
    localparam int M_TDATA_W      = 104;
    localparam int M_TUSER_W      = 2;
    localparam int M_FIELDS_W     = LOG2_W + LOAD_W + TIME_W;
    localparam int M_PAD_W        = M_TDATA_W - M_FIELDS_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ONESHOT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PERIODIC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE  = 2'd2;

    // constants
    localparam logic [TICK_W-1:0] FS_PER_NS  = 32'd1000000;
    localparam logic [TICK_W-1:0] TICK_RESET = 32'd10000000;

    // parameter defaults
    localparam int MAX_DIV_LOG2_DEF = 7;
    localparam int COUNT_W_DEF      = 32;

    // shared mul/div unit
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = 64;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int QUO_W     = 84;
    localparam int IDX_W     = 7;
    localparam int DIV_STEPS = 2;
    localparam logic [IDX_W-1:0] PROG_DIV_BITS = 7'd64;
    localparam logic [IDX_W-1:0] ADV_DIV_BITS  = 7'd84;
    localparam logic [IDX_W-1:0] NOW_DIV_BITS  = 7'd72;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROG_START,
        S_PROG_WAIT,
        S_ADV_DIFF,
        S_ADV_WAIT1,
        S_ADV_CLAMP,
        S_ADV_SUB,
        S_ADV_WAIT2,
        S_ADV_ADD,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL_LO,
        U_MUL_HI,
        U_DIV
    } t_unit_state;

    // floor(a * b / dvs), dividend taken from its low nbits bits
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [TICK_W-1:0]  dvs;
        logic [IDX_W-1:0]   nbits;
    } t_unit_cmd;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_unit_rsp;

endpackage

>>> src/tcps_muldiv.sv
// ----------------------------------------------------------------------------
// tcps_muldiv
// Shared 32x32 multiplier (two partial products) feeding a restoring
// divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tcps_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcps_pkg::t_unit_cmd  i_cmd,
    output tcps_pkg::t_unit_rsp  o_rsp
);

    localparam int MUL_A_W   = tcps_pkg::MUL_A_W;
    localparam int MUL_B_W   = tcps_pkg::MUL_B_W;
    localparam int MUL_P_W   = tcps_pkg::MUL_P_W;
    localparam int PROD_W    = tcps_pkg::PROD_W;
    localparam int QUO_W     = tcps_pkg::QUO_W;
    localparam int IDX_W     = tcps_pkg::IDX_W;
    localparam int TICK_W    = tcps_pkg::TICK_W;
    localparam int DIV_STEPS = tcps_pkg::DIV_STEPS;

    tcps_pkg::t_unit_state r_state, n_state;
    logic [MUL_A_W-1:0] r_a, n_a;
    logic [MUL_B_W-1:0] r_b, n_b;
    logic [TICK_W-1:0]  r_dvs, n_dvs;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [TICK_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_done, n_done;

    logic [MUL_B_W-1:0] w_mul_a;
    logic [MUL_P_W-1:0] w_mul;

    assign w_mul_a = (r_state == tcps_pkg::U_MUL_HI) ? r_a[MUL_A_W-1:MUL_B_W]
                                                     : r_a[MUL_B_W-1:0];
    assign w_mul   = MUL_P_W'(w_mul_a) * MUL_P_W'(r_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcps_pkg::U_IDLE: begin
                if (i_cmd.start) begin
                    n_state = tcps_pkg::U_MUL_LO;
                end
            end
            tcps_pkg::U_MUL_LO: n_state = tcps_pkg::U_MUL_HI;
            tcps_pkg::U_MUL_HI: n_state = tcps_pkg::U_DIV;
            tcps_pkg::U_DIV: begin
                if (r_idx == IDX_W'(DIV_STEPS - 1)) begin
                    n_state = tcps_pkg::U_IDLE;
                end
            end
            default: n_state = tcps_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        logic [TICK_W:0]    v_try;
        logic [TICK_W-1:0]  v_rem;
        logic [QUO_W-1:0]   v_quo;
        logic [IDX_W-1:0]   v_pos;
        n_a    = r_a;
        n_b    = r_b;
        n_dvs  = r_dvs;
        n_prod = r_prod;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_idx  = r_idx;
        n_done = 1'b0;
        v_rem  = r_rem;
        v_quo  = r_quo;
        v_try  = '0;
        v_pos  = r_idx;
        unique case (r_state)
            tcps_pkg::U_IDLE: begin
                if (i_cmd.start) begin
                    n_a   = i_cmd.a;
                    n_b   = i_cmd.b;
                    n_dvs = i_cmd.dvs;
                    n_idx = i_cmd.nbits - IDX_W'(1);
                    n_quo = '0;
                end
            end
            tcps_pkg::U_MUL_LO: begin
                n_prod = PROD_W'(w_mul);
            end
            tcps_pkg::U_MUL_HI: begin
                n_prod = r_prod + {w_mul, {MUL_B_W{1'b0}}};
                n_rem  = '0;
            end
            tcps_pkg::U_DIV: begin
                for (int j = 0; j < DIV_STEPS; j++) begin
                    v_pos = r_idx - IDX_W'(j);
                    v_try = {v_rem, r_prod[v_pos]};
                    if (v_try >= {1'b0, r_dvs}) begin
                        v_rem = TICK_W'(v_try - {1'b0, r_dvs});
                        v_quo = {v_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        v_rem = v_try[TICK_W-1:0];
                        v_quo = {v_quo[QUO_W-2:0], 1'b0};
                    end
                end
                n_rem = v_rem;
                n_quo = v_quo;
                n_idx = r_idx - IDX_W'(DIV_STEPS);
                if (r_idx == IDX_W'(DIV_STEPS - 1)) begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcps_pkg::U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_dvs  <= n_dvs;
        r_prod <= n_prod;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_idx  <= n_idx;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> src/timer_count_prescale_select.sv
// ----------------------------------------------------------------------------
// timer_count_prescale_select
// Program requests: one multiply/divide pass, then the result is loaded.
// Advance requests: two passes; empty queue or reserved request: no pass.
// One item at a time, next accept once the result is loaded (plus any output
// stall); every pass uses the shared multiplier/divider (2 quotient bits/cycle).
// Sync active-low reset: tick period 10000000 fs, divisor one, now zero, output empty.
// ----------------------------------------------------------------------------
`include "timer_count_prescale_select_macros.svh"

module timer_count_prescale_select #(
    parameter int MAX_DIVISOR_LOG2 = tcps_pkg::MAX_DIV_LOG2_DEF,
    parameter int COUNT_WIDTH      = tcps_pkg::COUNT_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcps_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // interval_ns[43:0], deadline_ns[107:44], queue_nonempty[108],
    // counter_value[140:109], zero pad
    input  logic [tcps_pkg::S_TDATA_W-1:0] i_s_tdata,
    // req_type[1:0]
    input  logic [tcps_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // divisor_log2[2:0], load_count[34:3], now_time_ns[98:35], zero pad
    output logic [tcps_pkg::M_TDATA_W-1:0] o_m_tdata,
    // periodic_mode[0], count_saturated[1]
    output logic [tcps_pkg::M_TUSER_W-1:0] o_m_tuser
);

    localparam int REQ_W      = tcps_pkg::REQ_W;
    localparam int INTERVAL_W = tcps_pkg::INTERVAL_W;
    localparam int TIME_W     = tcps_pkg::TIME_W;
    localparam int CNT_IN_W   = tcps_pkg::CNT_IN_W;
    localparam int LOG2_W     = tcps_pkg::LOG2_W;
    localparam int LOAD_W     = tcps_pkg::LOAD_W;
    localparam int TICK_W     = tcps_pkg::TICK_W;
    localparam int QUO_W      = tcps_pkg::QUO_W;
    localparam int MUL_A_W    = tcps_pkg::MUL_A_W;
    localparam int M_TDATA_W  = tcps_pkg::M_TDATA_W;
    localparam int M_TUSER_W  = tcps_pkg::M_TUSER_W;
    localparam int M_PAD_W    = tcps_pkg::M_PAD_W;
    localparam logic [LOAD_W-1:0] CMAX =
        LOAD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    tcps_pkg::t_state r_state, n_state;

    logic [TICK_W-1:0]     r_tick;
    logic [LOG2_W-1:0]     r_pdl, n_pdl;
    logic [TIME_W-1:0]     r_now, n_now;
    logic [INTERVAL_W-1:0] r_interval, n_interval;
    logic [TIME_W-1:0]     r_deadline, n_deadline;
    logic [CNT_IN_W-1:0]   r_counter, n_counter;
    logic [LOAD_W-1:0]     r_load, n_load;
    logic                  r_sat, n_sat;
    logic                  r_periodic, n_periodic;
    logic [LOAD_W-1:0]     r_t, n_t;
    logic                  r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]  r_out_tdata, n_out_tdata;
    logic [M_TUSER_W-1:0]  r_out_tuser, n_out_tuser;

    logic                  w_in_acc;
    logic [REQ_W-1:0]      w_in_req;
    logic                  w_in_nonempty;
    logic                  w_out_free;
    logic [TICK_W-1:0]     w_per;
    logic [TIME_W-1:0]     w_diff;
    logic [QUO_W-1:0]      w_qs;
    logic                  w_qs_over;
    logic [LOAD_W-1:0]     w_t2;
    logic [TIME_W-1:0]     w_q0;
    logic [LOG2_W-1:0]     w_pick_k;
    logic [LOAD_W-1:0]     w_pick_cnt;
    logic                  w_pick_found;

    tcps_pkg::t_unit_cmd   w_cmd;
    tcps_pkg::t_unit_rsp   w_rsp;

    tcps_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    assign o_s_tready    = (r_state == tcps_pkg::S_IDLE);
    assign w_in_acc      = i_s_tvalid && o_s_tready;
    assign w_in_req      = i_s_tuser[REQ_W-1:0];
    assign w_in_nonempty = i_s_tdata[tcps_pkg::IN_NONEMPTY_BIT];
    assign w_out_free    = !r_out_valid || i_m_tready;

    assign w_per  = (r_tick == '0) ? TICK_W'(1) : r_tick;
    assign w_diff = (r_deadline > r_now) ? (r_deadline - r_now) : '0;

    assign w_qs      = w_rsp.quo >> r_pdl;
    assign w_qs_over = |w_qs[QUO_W-1:COUNT_WIDTH];
    assign w_t2      = (LOAD_W'(r_counter) > r_t) ? '0 : (r_t - LOAD_W'(r_counter));
    assign w_q0      = w_rsp.quo[TIME_W-1:0];

    // smallest prescaler whose count fits
    always_comb begin
        logic              v_found;
        logic [LOG2_W-1:0] v_k;
        logic [LOAD_W-1:0] v_cnt;
        v_found = 1'b0;
        v_k     = LOG2_W'(MAX_DIVISOR_LOG2);
        v_cnt   = CMAX;
        for (int k = MAX_DIVISOR_LOG2; k >= 0; k--) begin
            if ((w_q0 >> (COUNT_WIDTH + k)) == '0) begin
                v_found = 1'b1;
                v_k     = LOG2_W'(k);
                v_cnt   = LOAD_W'(w_q0 >> k);
            end
        end
        w_pick_found = v_found;
        w_pick_k     = v_k;
        w_pick_cnt   = v_cnt;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcps_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_in_req) inside
                        tcps_pkg::REQ_ONESHOT, tcps_pkg::REQ_PERIODIC: begin
                            n_state = tcps_pkg::S_PROG_START;
                        end
                        tcps_pkg::REQ_ADVANCE: begin
                            n_state = w_in_nonempty ? tcps_pkg::S_ADV_DIFF
                                                    : tcps_pkg::S_FINISH;
                        end
                        default: n_state = tcps_pkg::S_FINISH;
                    endcase
                end
            end
            tcps_pkg::S_PROG_START: n_state = tcps_pkg::S_PROG_WAIT;
            tcps_pkg::S_PROG_WAIT: begin
                if (w_rsp.done) begin
                    n_state = tcps_pkg::S_FINISH;
                end
            end
            tcps_pkg::S_ADV_DIFF: n_state = tcps_pkg::S_ADV_WAIT1;
            tcps_pkg::S_ADV_WAIT1: begin
                if (w_rsp.done) begin
                    n_state = tcps_pkg::S_ADV_CLAMP;
                end
            end
            tcps_pkg::S_ADV_CLAMP: n_state = tcps_pkg::S_ADV_SUB;
            tcps_pkg::S_ADV_SUB:   n_state = tcps_pkg::S_ADV_WAIT2;
            tcps_pkg::S_ADV_WAIT2: begin
                if (w_rsp.done) begin
                    n_state = tcps_pkg::S_ADV_ADD;
                end
            end
            tcps_pkg::S_ADV_ADD: n_state = tcps_pkg::S_FINISH;
            tcps_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = tcps_pkg::S_IDLE;
                end
            end
            default: n_state = tcps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pdl       = r_pdl;
        n_now       = r_now;
        n_interval  = r_interval;
        n_deadline  = r_deadline;
        n_counter   = r_counter;
        n_load      = r_load;
        n_sat       = r_sat;
        n_periodic  = r_periodic;
        n_t         = r_t;
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;
        w_cmd       = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tcps_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_interval = i_s_tdata[tcps_pkg::IN_INTERVAL_LSB +: INTERVAL_W];
                    n_deadline = i_s_tdata[tcps_pkg::IN_DEADLINE_LSB +: TIME_W];
                    n_counter  = i_s_tdata[tcps_pkg::IN_COUNTER_LSB +: CNT_IN_W];
                    n_load     = '0;
                    n_sat      = 1'b0;
                    n_periodic = (w_in_req == tcps_pkg::REQ_PERIODIC);
                end
            end
            tcps_pkg::S_PROG_START: begin
                w_cmd.start = 1'b1;
                w_cmd.a     = MUL_A_W'(r_interval);
                w_cmd.b     = tcps_pkg::FS_PER_NS;
                w_cmd.dvs   = w_per;
                w_cmd.nbits = tcps_pkg::PROG_DIV_BITS;
            end
            tcps_pkg::S_PROG_WAIT: begin
                if (w_rsp.done) begin
                    n_pdl  = w_pick_k;
                    n_load = w_pick_cnt;
                    n_sat  = !w_pick_found;
                end
            end
            tcps_pkg::S_ADV_DIFF: begin
                w_cmd.start = 1'b1;
                w_cmd.a     = w_diff;
                w_cmd.b     = tcps_pkg::FS_PER_NS;
                w_cmd.dvs   = w_per;
                w_cmd.nbits = tcps_pkg::ADV_DIV_BITS;
            end
            tcps_pkg::S_ADV_CLAMP: begin
                n_t = w_qs_over ? CMAX : w_qs[LOAD_W-1:0];
            end
            tcps_pkg::S_ADV_SUB: begin
                w_cmd.start = 1'b1;
                w_cmd.a     = MUL_A_W'(w_t2) << r_pdl;
                w_cmd.b     = w_per;
                w_cmd.dvs   = tcps_pkg::FS_PER_NS;
                w_cmd.nbits = tcps_pkg::NOW_DIV_BITS;
            end
            tcps_pkg::S_ADV_ADD: begin
                n_now = r_now + w_q0;
            end
            tcps_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {{M_PAD_W{1'b0}}, r_now, r_load, r_pdl};
                    n_out_tuser = {r_sat, r_periodic};
                end
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= tcps_pkg::TICK_RESET;
        end else if (i_cfg_we) begin
            r_tick <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcps_pkg::S_IDLE;
            r_pdl       <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pdl       <= n_pdl;
            r_now       <= n_now;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_interval  <= n_interval;
        r_deadline  <= n_deadline;
        r_counter   <= n_counter;
        r_load      <= n_load;
        r_sat       <= n_sat;
        r_periodic  <= n_periodic;
        r_t         <= n_t;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // saturated count implies top prescaler and full-scale load
    `TCPS_ASSERT_IMPL(a_sat_full_scale, o_m_tvalid && o_m_tuser[1], (o_m_tdata[LOG2_W-1:0] == LOG2_W'(MAX_DIVISOR_LOG2)) && (o_m_tdata[LOG2_W+LOAD_W-1:LOG2_W] == CMAX), "saturated result without max prescaler and full count")
    // a new result only ever comes out of the finish step
    `TCPS_ASSERT_IMPL(a_out_from_finish, $rose(o_m_tvalid), $past(r_state) == tcps_pkg::S_FINISH, "output valid raised outside finish step")
    // running time only moves in the add step
    `TCPS_ASSERT_NEXT(a_now_hold, r_state != tcps_pkg::S_ADV_ADD, $stable(r_now), "running time changed outside add step")

endmodule
